/* rtl/aiau_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulator integer ALU package
// Operation codes, digit size of the shared multiplier and the control word
// that the sequencer hands to the shared arithmetic unit.
// ----------------------------------------------------------------------------
package aiau_pkg;

   // width of the operation code field
   localparam int CMD_WIDTH = 3;

   // operation codes
   localparam logic [CMD_WIDTH-1:0] OP_ADD = 3'd0;
   localparam logic [CMD_WIDTH-1:0] OP_SUB = 3'd1;
   localparam logic [CMD_WIDTH-1:0] OP_MUL = 3'd2;
   localparam logic [CMD_WIDTH-1:0] OP_DIV = 3'd3;
   localparam logic [CMD_WIDTH-1:0] OP_POW = 3'd4;
   localparam logic [CMD_WIDTH-1:0] OP_REM = 3'd5;

   // multiplier bits consumed per multiply step
   localparam int DIGIT_WIDTH = 8;

   // control word of the shared arithmetic unit
   typedef struct packed {
      logic sub;   // invert second operand and add one
      logic mul;   // add second operand times digit
   } alu_ctrl_type;

endpackage

/* rtl/aiau_alu_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// One adder with optional subtract and an optional narrow digit multiplier
// in front of it; used for add, subtract, negate, multiply and divide steps.
// ----------------------------------------------------------------------------
module aiau_alu_unit #(
   parameter int DATA_WIDTH = 32
) (
   input  aiau_pkg::alu_ctrl_type                ctrl,
   input  logic [DATA_WIDTH-1:0]                 op1,
   input  logic [DATA_WIDTH-1:0]                 op2,
   input  logic [aiau_pkg::DIGIT_WIDTH-1:0]      digit,
   output logic [DATA_WIDTH-1:0]                 sum,
   output logic                                  carry
);

   logic [DATA_WIDTH+aiau_pkg::DIGIT_WIDTH-1:0] prod_full;
   logic [DATA_WIDTH-1:0]                       addend;
   logic [DATA_WIDTH:0]                         total;

   // partial product of one multiplier digit
   assign prod_full = {{aiau_pkg::DIGIT_WIDTH{1'b0}}, op2} *
                      {{DATA_WIDTH{1'b0}}, digit};

   // pick the addend: partial product, operand or its complement
   always_comb begin
      if (ctrl.mul) begin
         addend = prod_full[DATA_WIDTH-1:0];
      end else begin
         addend = op2 ^ {DATA_WIDTH{ctrl.sub}};
      end
   end

   // carry out is the no-borrow flag when subtracting
   assign total = {1'b0, op1} + {1'b0, addend} + {{DATA_WIDTH{1'b0}}, ctrl.sub};
   assign sum   = total[DATA_WIDTH-1:0];
   assign carry = total[DATA_WIDTH];

endmodule

/* rtl/aiau_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulator ALU sequencer
// Runs one request at a time through the shared arithmetic unit: single step
// add and subtract, digit-serial multiply, restoring divide and
// square-and-multiply power built from the multiply loop.
// ----------------------------------------------------------------------------
module aiau_sequencer #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [aiau_pkg::CMD_WIDTH-1:0] req_cmd,
   input  logic [DATA_WIDTH-1:0]          req_opa,
   input  logic [DATA_WIDTH-1:0]          req_opb,
   input  logic [DATA_WIDTH-1:0]          prev_value,
   output logic                           ready,
   output logic                           res_valid,
   input  logic                           res_take,
   output logic [DATA_WIDTH-1:0]          res_value,
   output logic                           res_dz
);

   localparam int CNT_WIDTH = $clog2(DATA_WIDTH);
   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(DATA_WIDTH - 1);

   // sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_ADDSUB  = 4'd1;
   localparam logic [3:0] S_MUL     = 4'd2;
   localparam logic [3:0] S_ABS_A   = 4'd3;
   localparam logic [3:0] S_ABS_B   = 4'd4;
   localparam logic [3:0] S_DIV     = 4'd5;
   localparam logic [3:0] S_SIGN    = 4'd6;
   localparam logic [3:0] S_POW_BIT = 4'd7;
   localparam logic [3:0] S_POW_SQ  = 4'd8;
   localparam logic [3:0] S_DONE    = 4'd9;

   // where a finished multiply goes
   localparam logic [1:0] RET_PROD = 2'd0;
   localparam logic [1:0] RET_ACC  = 2'd1;
   localparam logic [1:0] RET_SQ   = 2'd2;

   logic [3:0]                     state_ff, state_in;
   logic [aiau_pkg::CMD_WIDTH-1:0] cmd_ff, cmd_in;
   logic [DATA_WIDTH-1:0]          acc_ff, acc_in;   // operand a, quotient, power acc
   logic [DATA_WIDTH-1:0]          opb_ff, opb_in;   // operand b, divisor, square
   logic [DATA_WIDTH-1:0]          exp_ff, exp_in;   // remaining exponent
   logic [DATA_WIDTH-1:0]          mx_ff, mx_in;     // multiplicand
   logic [DATA_WIDTH-1:0]          my_ff, my_in;     // multiplier
   logic [DATA_WIDTH-1:0]          mp_ff, mp_in;     // product or remainder
   logic [1:0]                     ret_ff, ret_in;
   logic [CNT_WIDTH-1:0]           cnt_ff, cnt_in;
   logic                           neg_a_ff, neg_a_in;
   logic                           neg_b_ff, neg_b_in;
   logic [DATA_WIDTH-1:0]          res_ff, res_in;
   logic                           dz_ff, dz_in;

   aiau_pkg::alu_ctrl_type         alu_ctrl;
   logic [DATA_WIDTH-1:0]          alu_op1;
   logic [DATA_WIDTH-1:0]          alu_op2;
   logic [aiau_pkg::DIGIT_WIDTH-1:0] alu_digit;
   logic [DATA_WIDTH-1:0]          alu_sum;
   logic                           alu_carry;
   logic [DATA_WIDTH-1:0]          rem_shift;
   logic                           quo_neg;

   aiau_alu_unit #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_alu (
      .ctrl  (alu_ctrl),
      .op1   (alu_op1),
      .op2   (alu_op2),
      .digit (alu_digit),
      .sum   (alu_sum),
      .carry (alu_carry)
   );

   // remainder shifted left with the next dividend bit
   assign rem_shift = {mp_ff[DATA_WIDTH-2:0], acc_ff[DATA_WIDTH-1]};
   assign quo_neg   = (cmd_ff == aiau_pkg::OP_DIV) ? (neg_a_ff ^ neg_b_ff) : neg_a_ff;

   // steer operands into the shared unit
   always_comb begin
      alu_ctrl  = '0;
      alu_op1   = '0;
      alu_op2   = '0;
      alu_digit = '0;
      case (state_ff)
         S_ADDSUB: begin
            alu_ctrl.sub = (cmd_ff == aiau_pkg::OP_SUB);
            alu_op1      = acc_ff;
            alu_op2      = opb_ff;
         end
         S_MUL: begin
            alu_ctrl.mul = 1'b1;
            alu_op1      = mp_ff;
            alu_op2      = mx_ff;
            alu_digit    = my_ff[aiau_pkg::DIGIT_WIDTH-1:0];
         end
         S_ABS_A: begin
            alu_ctrl.sub = 1'b1;
            alu_op2      = acc_ff;
         end
         S_ABS_B: begin
            alu_ctrl.sub = 1'b1;
            alu_op2      = opb_ff;
         end
         S_DIV: begin
            alu_ctrl.sub = 1'b1;
            alu_op1      = rem_shift;
            alu_op2      = opb_ff;
         end
         S_SIGN: begin
            alu_ctrl.sub = 1'b1;
            alu_op2      = (cmd_ff == aiau_pkg::OP_DIV) ? acc_ff : mp_ff;
         end
         default: begin
            alu_ctrl = '0;
         end
      endcase
   end

   // sequence one request
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      acc_in   = acc_ff;
      opb_in   = opb_ff;
      exp_in   = exp_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;
      mp_in    = mp_ff;
      ret_in   = ret_ff;
      cnt_in   = cnt_ff;
      neg_a_in = neg_a_ff;
      neg_b_in = neg_b_ff;
      res_in   = res_ff;
      dz_in    = dz_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in = req_cmd;
               acc_in = req_opa;
               opb_in = req_opb;
               dz_in  = 1'b0;
               case (req_cmd)
                  aiau_pkg::OP_ADD, aiau_pkg::OP_SUB: begin
                     state_in = S_ADDSUB;
                  end
                  aiau_pkg::OP_MUL: begin
                     mx_in    = req_opa;
                     my_in    = req_opb;
                     mp_in    = '0;
                     ret_in   = RET_PROD;
                     state_in = S_MUL;
                  end
                  aiau_pkg::OP_DIV, aiau_pkg::OP_REM: begin
                     if (req_opb == '0) begin
                        // zero divisor: flag it and return zero
                        res_in   = '0;
                        dz_in    = 1'b1;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_ABS_A;
                     end
                  end
                  aiau_pkg::OP_POW: begin
                     if (req_opb == '0) begin
                        res_in   = DATA_WIDTH'(1);
                        state_in = S_DONE;
                     end else if (req_opb[DATA_WIDTH-1]) begin
                        // negative exponent returns the base
                        res_in   = req_opa;
                        state_in = S_DONE;
                     end else begin
                        acc_in   = DATA_WIDTH'(1);
                        opb_in   = req_opa;
                        exp_in   = req_opb;
                        state_in = S_POW_BIT;
                     end
                  end
                  default: begin
                     // unused code: repeat the stored result
                     res_in   = prev_value;
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_ADDSUB: begin
            res_in   = alu_sum;
            state_in = S_DONE;
         end
         S_MUL: begin
            if (my_ff == '0) begin
               case (ret_ff)
                  RET_ACC: begin
                     acc_in   = mp_ff;
                     state_in = S_POW_SQ;
                  end
                  RET_SQ: begin
                     opb_in   = mp_ff;
                     state_in = S_POW_BIT;
                  end
                  default: begin
                     res_in   = mp_ff;
                     state_in = S_DONE;
                  end
               endcase
            end else begin
               // add one digit's partial product, advance the digit
               mp_in = alu_sum;
               mx_in = mx_ff << aiau_pkg::DIGIT_WIDTH;
               my_in = my_ff >> aiau_pkg::DIGIT_WIDTH;
            end
         end
         S_ABS_A: begin
            neg_a_in = acc_ff[DATA_WIDTH-1];
            if (acc_ff[DATA_WIDTH-1]) begin
               acc_in = alu_sum;
            end
            state_in = S_ABS_B;
         end
         S_ABS_B: begin
            neg_b_in = opb_ff[DATA_WIDTH-1];
            if (opb_ff[DATA_WIDTH-1]) begin
               opb_in = alu_sum;
            end
            mp_in    = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            // one restoring step: keep the difference when no borrow
            mp_in  = alu_carry ? alu_sum : rem_shift;
            acc_in = {acc_ff[DATA_WIDTH-2:0], alu_carry};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = S_SIGN;
            end
         end
         S_SIGN: begin
            if (quo_neg) begin
               res_in = alu_sum;
            end else begin
               res_in = (cmd_ff == aiau_pkg::OP_DIV) ? acc_ff : mp_ff;
            end
            state_in = S_DONE;
         end
         S_POW_BIT: begin
            if (exp_ff[0]) begin
               mx_in    = acc_ff;
               my_in    = opb_ff;
               mp_in    = '0;
               ret_in   = RET_ACC;
               state_in = S_MUL;
            end else begin
               state_in = S_POW_SQ;
            end
         end
         S_POW_SQ: begin
            exp_in = exp_ff >> 1;
            if ((exp_ff >> 1) == '0) begin
               res_in   = acc_ff;
               state_in = S_DONE;
            end else begin
               mx_in    = opb_ff;
               my_in    = opb_ff;
               mp_in    = '0;
               ret_in   = RET_SQ;
               state_in = S_MUL;
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      acc_ff   <= acc_in;
      opb_ff   <= opb_in;
      exp_ff   <= exp_in;
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      mp_ff    <= mp_in;
      ret_ff   <= ret_in;
      cnt_ff   <= cnt_in;
      neg_a_ff <= neg_a_in;
      neg_b_ff <= neg_b_in;
      res_ff   <= res_in;
      dz_ff    <= dz_in;
   end

   assign ready     = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res_value = res_ff;
   assign res_dz    = dz_ff;

endmodule

/* rtl/accumulator_integer_alu_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulator integer ALU
// Add, subtract, multiply, divide, remainder and power on signed words, with
// the last result available as the first operand of the next request.
// ----------------------------------------------------------------------------
// Usage:
//   A request enters on req_* when req_tvalid and req_tready are both high;
//   its result leaves on rsp_* under the same handshake. One request is in
//   the arithmetic at a time and req_tready is low while it runs.
//   Run time from accept to rsp_tvalid by operation:
//     add, subtract, unused codes, zero divisor, trivial power: no loop
//     multiply: digit-serial, shorter when the multiplier has high zero bytes
//     divide, remainder: set by the one-bit-per-cycle divide loop
//     power: set by the digit multiplier, repeated per exponent bit
//   The next request is taken in the cycle after the sequencer hands on its
//   result, also while it still waits in the output register. When the receiver
//   stalls, the result holds and a finished following result waits in the
//   sequencer. Reset empties the output register, returns the sequencer to
//   idle and clears the stored previous result to zero.
// ----------------------------------------------------------------------------
module accumulator_integer_alu_unit #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            req_tvalid,
   output logic                                            req_tready,
   // cmd[2:0], operand_a, operand_b, zero pad
   input  logic [((aiau_pkg::CMD_WIDTH+2*DATA_WIDTH+7)/8)*8-1:0] req_tdata,
   // use_previous
   input  logic [0:0]                                      req_tuser,
   output logic                                            rsp_tvalid,
   input  logic                                            rsp_tready,
   // result_value, zero pad
   output logic [((DATA_WIDTH+7)/8)*8-1:0]                 rsp_tdata,
   // divide_by_zero
   output logic [0:0]                                      rsp_tuser
);

   localparam int RSP_TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8;
   localparam int OPA_LSB = aiau_pkg::CMD_WIDTH;
   localparam int OPB_LSB = aiau_pkg::CMD_WIDTH + DATA_WIDTH;

   logic [aiau_pkg::CMD_WIDTH-1:0] req_cmd;
   logic [DATA_WIDTH-1:0]          req_opa;
   logic [DATA_WIDTH-1:0]          req_opb;
   logic [DATA_WIDTH-1:0]          opa_sel;
   logic                           req_fire;
   logic                           seq_ready;
   logic                           res_valid;
   logic                           res_take;
   logic [DATA_WIDTH-1:0]          res_value;
   logic                           res_dz;

   logic [DATA_WIDTH-1:0]          prev_ff;
   logic                           rsp_valid_ff;
   logic [DATA_WIDTH-1:0]          rsp_value_ff;
   logic                           rsp_dz_ff;

   // unpack the request
   assign req_cmd  = req_tdata[aiau_pkg::CMD_WIDTH-1:0];
   assign req_opa  = req_tdata[OPA_LSB +: DATA_WIDTH];
   assign req_opb  = req_tdata[OPB_LSB +: DATA_WIDTH];
   assign opa_sel  = req_tuser[0] ? prev_ff : req_opa;
   assign req_fire = req_tvalid && seq_ready;

   aiau_sequencer #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .start      (req_fire),
      .req_cmd    (req_cmd),
      .req_opa    (opa_sel),
      .req_opb    (req_opb),
      .prev_value (prev_ff),
      .ready      (seq_ready),
      .res_valid  (res_valid),
      .res_take   (res_take),
      .res_value  (res_value),
      .res_dz     (res_dz)
   );

   // move a finished result into an empty or draining output register
   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
         prev_ff      <= res_value;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_value_ff <= res_value;
         rsp_dz_ff    <= res_dz;
      end
   end

   assign req_tready   = seq_ready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = RSP_TDATA_WIDTH'(rsp_value_ff);
   assign rsp_tuser[0] = rsp_dz_ff;

endmodule

/* rtl/aiau_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulator ALU port checker
// Watches the request and response ports of the top level over time.
// ----------------------------------------------------------------------------
module aiau_checker #(
   parameter int DATA_WIDTH = 32
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [((DATA_WIDTH+7)/8)*8-1:0]     rsp_tdata,
   input logic [0:0]                          rsp_tuser
);

   // a stalled response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response payload changed while stalled");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // an accepted request occupies the sequencer
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one still running");

   // a zero divisor result is zero
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("divide by zero with nonzero result");

endmodule

bind accumulator_integer_alu_unit aiau_checker #(
   .DATA_WIDTH(DATA_WIDTH)
) u_aiau_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
